// ===== hdl/glbdf_pkg.sv =====
// Shared types, codes and constants of the GLB container deframer.
`timescale 1ns / 1ps

package glbdf_pkg;

  localparam logic [31:0] GLB_MAGIC = 32'h4654_6C67;
  localparam logic [3:0]  FILE_HDR_LAST  = 4'd11;
  localparam logic [3:0]  CHUNK_HDR_LAST = 4'd7;
  localparam logic [3:0]  LEN_WORD_LAST  = 4'd3;
  localparam logic [3:0]  VER_WORD_LAST  = 4'd7;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [2:0] K_HEADER = 3'd0;
  localparam logic [2:0] K_CHUNK  = 3'd1;
  localparam logic [2:0] K_DATA   = 3'd2;
  localparam logic [2:0] K_DONE   = 3'd3;
  localparam logic [2:0] K_ERROR  = 3'd4;

  localparam logic [1:0] E_TOO_SHORT = 2'd0;
  localparam logic [1:0] E_BAD_MAGIC = 2'd1;
  localparam logic [1:0] E_HDR_CUT   = 2'd2;
  localparam logic [1:0] E_OVERRUN   = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        last_in_chunk;
    logic [31:0] file_version;
    logic [31:0] file_length;
    logic [31:0] chunk_kind_word;
    logic [31:0] chunk_size;
    logic [1:0]  error_code;
  } out_t;

  // One classified input byte: a first result and an optional trailing
  // file done or error result.
  typedef struct packed {
    out_t       first;
    logic       sec_valid;
    logic       sec_is_error;
    logic [1:0] sec_code;
  } entry_t;

endpackage

// ===== hdl/glbdf_front.sv =====
// Front end: byte parser that classifies each byte into queue entries.
`timescale 1ns / 1ps

module glbdf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  glbdf_pkg::in_t    in_data,
  input  logic              q_full,
  output logic              q_push,
  output glbdf_pkg::entry_t q_entry
);

  typedef enum logic [1:0] {
    PH_FILE_HDR,
    PH_CHUNK_HDR,
    PH_DATA,
    PH_DRAIN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [31:0] version_r, version_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;
  logic        take;
  logic        eof;
  logic [31:0] gathered;
  glbdf_pkg::entry_t ent;
  logic        has_result;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign eof      = in_data.end_of_file;
  assign gathered = {in_data.in_byte, gather_r[31:8]};

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    gather_nxt  = gather_r;
    version_nxt = version_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    ent         = '0;
    has_result  = 1'b0;
    case (phase_r)
      PH_FILE_HDR: begin
        gather_nxt = gathered;
        // The magic word sits in the length register until the header ends.
        if (cnt_r == glbdf_pkg::LEN_WORD_LAST) begin
          len_nxt = gathered;
        end else if (cnt_r == glbdf_pkg::VER_WORD_LAST) begin
          version_nxt = gathered;
        end
        if (cnt_r != glbdf_pkg::FILE_HDR_LAST) begin
          cnt_nxt = cnt_r + 4'd1;
          if (eof) begin
            has_result             = 1'b1;
            ent.first.kind         = glbdf_pkg::K_ERROR;
            ent.first.error_code   = glbdf_pkg::E_TOO_SHORT;
            cnt_nxt                = '0;
          end
        end else begin
          cnt_nxt    = '0;
          has_result = 1'b1;
          if (len_r != glbdf_pkg::GLB_MAGIC) begin
            ent.first.kind       = glbdf_pkg::K_ERROR;
            ent.first.error_code = glbdf_pkg::E_BAD_MAGIC;
            phase_nxt            = eof ? PH_FILE_HDR : PH_DRAIN;
          end else begin
            ent.first.kind         = glbdf_pkg::K_HEADER;
            ent.first.file_version = version_r;
            ent.first.file_length  = gathered;
            phase_nxt              = eof ? PH_FILE_HDR : PH_CHUNK_HDR;
            ent.sec_valid          = eof;
          end
        end
      end
      PH_CHUNK_HDR: begin
        gather_nxt = gathered;
        if (cnt_r == glbdf_pkg::LEN_WORD_LAST) begin
          len_nxt = gathered;
        end
        if (cnt_r != glbdf_pkg::CHUNK_HDR_LAST) begin
          cnt_nxt = cnt_r + 4'd1;
          if (eof) begin
            has_result           = 1'b1;
            ent.first.kind       = glbdf_pkg::K_ERROR;
            ent.first.error_code = glbdf_pkg::E_HDR_CUT;
            phase_nxt            = PH_FILE_HDR;
            cnt_nxt              = '0;
          end
        end else begin
          cnt_nxt                   = '0;
          has_result                = 1'b1;
          ent.first.kind            = glbdf_pkg::K_CHUNK;
          ent.first.chunk_kind_word = gathered;
          ent.first.chunk_size      = len_r;
          if (len_r == '0) begin
            ent.sec_valid = eof;
            if (eof) begin
              phase_nxt = PH_FILE_HDR;
            end
          end else begin
            left_nxt         = len_r;
            phase_nxt        = eof ? PH_FILE_HDR : PH_DATA;
            ent.sec_valid    = eof;
            ent.sec_is_error = 1'b1;
            ent.sec_code     = glbdf_pkg::E_OVERRUN;
          end
        end
      end
      PH_DATA: begin
        has_result              = 1'b1;
        ent.first.kind          = glbdf_pkg::K_DATA;
        ent.first.data_byte     = in_data.in_byte;
        ent.first.last_in_chunk = (left_r == 32'd1);
        left_nxt                = left_r - 32'd1;
        ent.sec_valid           = eof;
        if (left_r == 32'd1) begin
          cnt_nxt   = '0;
          phase_nxt = eof ? PH_FILE_HDR : PH_CHUNK_HDR;
        end else if (eof) begin
          ent.sec_is_error = 1'b1;
          ent.sec_code     = glbdf_pkg::E_OVERRUN;
          phase_nxt        = PH_FILE_HDR;
          cnt_nxt          = '0;
        end
      end
      PH_DRAIN: begin
        if (eof) begin
          phase_nxt = PH_FILE_HDR;
          cnt_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_FILE_HDR;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign q_push  = take && has_result;
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE_HDR;
      cnt_r   <= '0;
      left_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      gather_r  <= gather_nxt;
      version_r <= version_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

// ===== hdl/glbdf_queue.sv =====
// Short queue of classified entries between the parser and the output stage.
`timescale 1ns / 1ps

module glbdf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  glbdf_pkg::entry_t     push_entry,
  input  logic                  pop,
  output glbdf_pkg::entry_t     head,
  output logic                  full,
  output logic                  empty,
  output logic [glbdf_pkg::QAW:0] count
);

  glbdf_pkg::entry_t           mem_r [glbdf_pkg::QDEPTH];
  logic [glbdf_pkg::QAW-1:0]   wr_ptr_r;
  logic [glbdf_pkg::QAW-1:0]   rd_ptr_r;
  logic [glbdf_pkg::QAW:0]     count_r, count_nxt;

  assign head  = mem_r[rd_ptr_r];
  assign full  = (count_r == (glbdf_pkg::QAW+1)'(glbdf_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hdl/glbdf_back.sv =====
// Back end: output register that emits one or two results per queue entry.
`timescale 1ns / 1ps

module glbdf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  glbdf_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output glbdf_pkg::out_t   out_data
);

  logic             out_valid_r;
  glbdf_pkg::out_t  out_r, out_nxt;
  logic             sec_pend_r;
  logic             sec_err_r;
  logic [1:0]       sec_code_r;
  logic             load;

  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !sec_pend_r && !empty;

  always_comb begin
    out_nxt = head.first;
    if (sec_pend_r) begin
      out_nxt = '0;
      if (sec_err_r) begin
        out_nxt.kind       = glbdf_pkg::K_ERROR;
        out_nxt.error_code = sec_code_r;
      end else begin
        out_nxt.kind = glbdf_pkg::K_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_pend_r  <= 1'b0;
    end else if (load) begin
      out_valid_r <= sec_pend_r || !empty;
      sec_pend_r  <= !sec_pend_r && !empty && head.sec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
    if (pop) begin
      sec_err_r  <= head.sec_is_error;
      sec_code_r <= head.sec_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/glb_container_deframer.sv =====
// Usage notes:
// Streaming deframer for binary glTF (GLB) files, fed one byte per request.
// Input channel: in_valid / in_stall / in_data carries a byte and an
// end-of-file mark on the final byte of each file.
// Result channel: out_valid / out_stall / out_data carries header ok,
// chunk start, data byte, file done and error results.
// A byte is taken at a clock edge with in_valid high and in_stall low.
// A result is taken at an edge with out_valid high and out_stall low.
// The first result of a byte is written into the queue and then loaded
// into the output register, which drives the result channel.
// Throughput: one byte per cycle while the receiver keeps up; a byte that
// yields two results (a trailing file done or error) occupies the output
// register for both results in turn, and a four-entry queue absorbs those bursts.
// Bytes of headers that give no result are taken without writing the queue.
// When the receiver stalls, the result holds and the queue fills; in_stall
// rises once the queue is full.
// Reset (rst_n low, synchronous) empties the queue and output and returns
// the parser to the start of a file header.
`timescale 1ns / 1ps

module glb_container_deframer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  glbdf_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output glbdf_pkg::out_t  out_data
);

  logic                    q_push;
  logic                    q_pop;
  logic                    q_full;
  logic                    q_empty;
  logic [glbdf_pkg::QAW:0] q_count;
  glbdf_pkg::entry_t       q_in;
  glbdf_pkg::entry_t       q_head;

  glbdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  glbdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty),
    .count      (q_count)
  );

  glbdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !q_pop) else $error("queue read while empty");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (glbdf_pkg::QAW+1)'(glbdf_pkg::QDEPTH))
    else $error("queue count out of range");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind <= glbdf_pkg::K_ERROR))
    else $error("illegal result kind");
`endif

endmodule
